// ----- rtl/umc_pkg.sv -----
// Shared types and constants for the unsharp mask combine pipeline.
`timescale 1ns / 1ps
`default_nettype none
package umc_pkg;

  localparam int QBITS  = 29;   // quotient bits, one divider cell each
  localparam int DIVW   = 12;   // divisor width (combined alpha below full scale)
  localparam int NCOMP  = 3;    // luma, cb, cr

  // Data that rides along with every pixel through the divider chain.
  typedef struct packed {
    logic [NCOMP-1:0][15:0] o;       // original components
    logic [NCOMP-1:0][16:0] dd;      // direct differences, signed
    logic [NCOMP-1:0]       neg;     // numerator sign
    logic [12:0]            oa;      // original alpha
    logic [DIVW-1:0]        divisor; // combined alpha, low bits
    logic                   bypass;  // strength zero or alpha zero
    logic                   direct;  // alpha at or above full scale
  } umc_side_t;

  // Partial remainder and shifting dividend/quotient word of one component.
  typedef struct packed {
    logic [DIVW-1:0]  rem;
    logic [QBITS-1:0] dq;
  } umc_div_t;

endpackage
`default_nettype wire

// ----- rtl/umc_div_cell.sv -----
// One restoring division step for three components, registered.
`timescale 1ns / 1ps
`default_nettype none
module umc_div_cell (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      en,
  input  wire logic                                      in_valid,
  input  wire umc_pkg::umc_side_t                        in_side,
  input  wire umc_pkg::umc_div_t [umc_pkg::NCOMP-1:0]    in_div,
  output logic                                           out_valid_r,
  output umc_pkg::umc_side_t                             out_side_r,
  output umc_pkg::umc_div_t [umc_pkg::NCOMP-1:0]         out_div_r
);

  logic [umc_pkg::NCOMP-1:0][umc_pkg::DIVW:0] t;
  logic [umc_pkg::NCOMP-1:0][umc_pkg::DIVW:0] diff;
  logic [umc_pkg::NCOMP-1:0]                  ge;
  umc_pkg::umc_div_t [umc_pkg::NCOMP-1:0]     div_nxt;

  always_comb begin
    for (int i = 0; i < umc_pkg::NCOMP; i++) begin
      t[i]    = {in_div[i].rem, in_div[i].dq[umc_pkg::QBITS-1]};
      diff[i] = t[i] - {1'b0, in_side.divisor};
      ge[i]   = t[i] >= {1'b0, in_side.divisor};
      div_nxt[i].rem = ge[i] ? diff[i][umc_pkg::DIVW-1:0] : t[i][umc_pkg::DIVW-1:0];
      div_nxt[i].dq  = {in_div[i].dq[umc_pkg::QBITS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= in_side;
      out_div_r  <= div_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/umc_post.sv -----
// Scaling, luma fold-back and output register after the divider chain.
`timescale 1ns / 1ps
`default_nettype none
module umc_post (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  input  wire umc_pkg::umc_side_t                           in_side,
  input  wire logic [umc_pkg::NCOMP-1:0][umc_pkg::QBITS-1:0] in_q,
  input  wire logic [12:0]                                  intensity,
  input  wire logic                                         out_tready,
  output logic                                              en,
  output logic                                              out_tvalid_r,
  output logic [63:0]                                       out_tdata_r
);

  // Stage 1: select difference, multiply by intensity.
  logic [umc_pkg::NCOMP-1:0][30:0] d;
  logic [umc_pkg::NCOMP-1:0][44:0] p1_prod_r;
  umc_pkg::umc_side_t              p1_side_r;
  logic                            p1_valid_r;

  // Stage 2: add back to the original.
  logic [umc_pkg::NCOMP-1:0][33:0] r2_nxt;
  logic [umc_pkg::NCOMP-1:0][33:0] r2_r;
  umc_pkg::umc_side_t              p2_side_r;
  logic                            p2_valid_r;

  // Stage 3: chroma scaling for negative luma.
  logic [33:0]                     s;
  logic [umc_pkg::NCOMP-1:0][15:0] p3_lo_r;
  logic [1:0][25:0]                p3_prod_r;
  logic [umc_pkg::NCOMP-1:0][15:0] p3_o_r;
  logic [12:0]                     p3_oa_r;
  logic                            p3_bypass_r;
  logic                            p3_fix_r;
  logic                            p3_spos_r;
  logic                            p3_valid_r;

  // Stage 4: output register.
  logic [63:0]                     out_nxt;

  assign en = !out_tvalid_r || out_tready;

  always_comb begin
    for (int i = 0; i < umc_pkg::NCOMP; i++) begin
      if (in_side.direct) begin
        d[i] = 31'($signed(in_side.dd[i]));
      end else if (in_side.neg[i]) begin
        d[i] = -{2'b00, in_q[i]};
      end else begin
        d[i] = {2'b00, in_q[i]};
      end
      r2_nxt[i] = 34'($signed(p1_side_r.o[i])) + 34'($signed(p1_prod_r[i]) >>> 12);
    end
    s = r2_r[0] + 34'd1024;
  end

  always_comb begin
    out_nxt = '0;
    out_nxt[60:48] = p3_oa_r;
    if (p3_bypass_r) begin
      out_nxt[15:0]  = p3_o_r[0];
      out_nxt[31:16] = p3_o_r[1];
      out_nxt[47:32] = p3_o_r[2];
    end else if (p3_fix_r) begin
      out_nxt[15:0]  = 16'd0;
      out_nxt[31:16] = p3_spos_r ? p3_prod_r[0][25:10] : 16'd0;
      out_nxt[47:32] = p3_spos_r ? p3_prod_r[1][25:10] : 16'd0;
    end else begin
      out_nxt[15:0]  = p3_lo_r[0];
      out_nxt[31:16] = p3_lo_r[1];
      out_nxt[47:32] = p3_lo_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r   <= 1'b0;
      p2_valid_r   <= 1'b0;
      p3_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r   <= in_valid;
      p2_valid_r   <= p1_valid_r;
      p3_valid_r   <= p2_valid_r;
      out_tvalid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < umc_pkg::NCOMP; i++) begin
        p1_prod_r[i] <= 45'($signed(d[i]) * $signed({1'b0, intensity}));
        r2_r[i]      <= r2_nxt[i];
        p3_lo_r[i]   <= r2_r[i][15:0];
      end
      p1_side_r    <= in_side;
      p2_side_r    <= p1_side_r;
      // Low product bits depend only on low operand bits; the output keeps 16.
      p3_prod_r[0] <= 26'(r2_r[1][25:0] * s[25:0]);
      p3_prod_r[1] <= 26'(r2_r[2][25:0] * s[25:0]);
      p3_o_r       <= p2_side_r.o;
      p3_oa_r      <= p2_side_r.oa;
      p3_bypass_r  <= p2_side_r.bypass;
      p3_fix_r     <= r2_r[0][33];
      p3_spos_r    <= !s[33] && (s != 34'd0);
      out_tdata_r  <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/unsharp_mask_combine_yca.sv -----
// Top level of the unsharp mask combine pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Channel     Direction  Transaction
// in_*        slave      one original pixel and its blurred premultiplied twin
// out_*       master     one sharpened pixel
// cfg_*       write      strength register
//
// Each pixel passes through one front stage that forms the combined alpha and
// the numerators, a chain of 29 divider cells (one quotient bit per cell), and
// four stages of scaling and output. A new pixel enters every cycle while the
// output is not stalled. Reset is synchronous and clears valid bits and strength.
// When the output register holds an untaken transaction, the whole pipeline
// holds and in_tready drops.
module unsharp_mask_combine_yca (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // orig_luma, orig_cb, orig_cr, orig_alpha, blur_luma, blur_cb, blur_cr,
  // blur_alpha, from bit 0 up, then zero fill
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_luma, out_cb, out_cr, out_alpha, from bit 0 up, then zero fill
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [9:0]   cfg_wdata
);

  localparam int QB = umc_pkg::QBITS;

  logic [9:0]  strength_r;
  logic [12:0] intensity_r;
  logic [38:0] int_prod;
  logic        en;

  // Front stage signals.
  logic [2:0][15:0] o_in;
  logic [2:0][15:0] b_in;
  logic [12:0]      oa_in;
  logic [12:0]      ba_in;
  logic [25:0]      a_prod;
  logic [13:0]      a;
  logic [2:0][30:0] n;
  umc_pkg::umc_side_t                  side_nxt;
  umc_pkg::umc_div_t [2:0]             div_nxt;

  logic                                c_valid [0:QB];
  umc_pkg::umc_side_t                  c_side  [0:QB];
  umc_pkg::umc_div_t [2:0]             c_div   [0:QB];
  logic [2:0][QB-1:0]                  q_last;

  // Intensity is strength*512/125, done as a reciprocal multiply that is
  // exact over the whole 10-bit strength range.
  assign int_prod = {strength_r, 9'd0} * 20'd536871;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= 10'd0;
    end else if (cfg_we) begin
      strength_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    intensity_r <= int_prod[38:26];
  end

  assign in_tready = en;

  always_comb begin
    o_in[0] = in_tdata[15:0];
    o_in[1] = in_tdata[31:16];
    o_in[2] = in_tdata[47:32];
    oa_in   = in_tdata[60:48];
    b_in[0] = in_tdata[76:61];
    b_in[1] = in_tdata[92:77];
    b_in[2] = in_tdata[108:93];
    ba_in   = in_tdata[121:109];
    a_prod  = ba_in * oa_in;
    a       = a_prod[25:12];
    for (int i = 0; i < 3; i++) begin
      // Numerator of the unpremultiply: orig*alpha - blur*4096.
      n[i] = 31'($signed(o_in[i]) * $signed({1'b0, oa_in}))
           - 31'($signed({b_in[i], 12'd0}));
      side_nxt.o[i]   = o_in[i];
      side_nxt.dd[i]  = 17'($signed(o_in[i])) - 17'($signed(b_in[i]));
      side_nxt.neg[i] = n[i][30];
      div_nxt[i].rem  = '0;
      div_nxt[i].dq   = n[i][30] ? QB'(-n[i]) : n[i][QB-1:0];
    end
    side_nxt.oa      = oa_in;
    side_nxt.divisor = a[umc_pkg::DIVW-1:0];
    side_nxt.bypass  = (strength_r == 10'd0) || (a == 14'd0);
    side_nxt.direct  = |a[13:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side[0] <= side_nxt;
      c_div[0]  <= div_nxt;
    end
  end

  // Divider chain: each cell resolves one quotient bit, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_cell
    umc_div_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (c_valid[k]),
      .in_side     (c_side[k]),
      .in_div      (c_div[k]),
      .out_valid_r (c_valid[k+1]),
      .out_side_r  (c_side[k+1]),
      .out_div_r   (c_div[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_last[i] = c_div[QB][i].dq;
    end
  end

  umc_post u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (c_valid[QB]),
    .in_side      (c_side[QB]),
    .in_q         (q_last),
    .intensity    (intensity_r),
    .out_tready   (out_tready),
    .en           (en),
    .out_tvalid_r (out_tvalid),
    .out_tdata_r  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_unsharp_mask_combine_yca.sv -----
// Self-checking testbench for the unsharp mask combine pipeline.
`timescale 1ns / 1ps
module tb_unsharp_mask_combine_yca;

  // Pipeline depth from input to output.
  localparam int PIPE_LAT = 34;
  localparam int N_RANDOM = 950;

  // One pixel transaction on the input side.
  typedef struct packed {
    logic [12:0] blur_alpha;
    logic [15:0] blur_cr;
    logic [15:0] blur_cb;
    logic [15:0] blur_luma;
    logic [12:0] orig_alpha;
    logic [15:0] orig_cr;
    logic [15:0] orig_cb;
    logic [15:0] orig_luma;
  } pixel_in_t;

  // One sharpened pixel on the output side.
  typedef struct packed {
    logic [12:0] alpha;
    logic [15:0] cr;
    logic [15:0] cb;
    logic [15:0] luma;
  } pixel_out_t;

  // A row of the directed table. When has_exp is set, the expected pixel is
  // typed in and is also cross-checked against the predictor.
  typedef struct {
    pixel_in_t  px;
    bit         has_exp;
    pixel_out_t exp_px;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_we;
  logic [9:0]   cfg_wdata;

  unsharp_mask_combine_yca dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // The testbench's own copy of the strength register.
  logic [9:0]  strength_q;
  pixel_out_t  sharpened_q[$];
  int          n_errors;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: the slowest correct run, about 1000 pixels with the longest
  // sender gaps and receiver stalls, stays far below this timeout.
  initial begin
    #2000000;
    $display("unsharp_mask_combine_yca: mismatch");
    $finish;
  end

  // Floor division by 2^k of a signed wide value.
  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  // Computes the sharpened pixel for one input pixel at the current strength.
  function automatic pixel_out_t sharpen_pixel(pixel_in_t px, logic [9:0] str);
    longint oa, ba, comb, intens, d, s;
    longint o[3], b[3], r[3];
    pixel_out_t res;
    oa = longint'(px.orig_alpha);
    ba = longint'(px.blur_alpha);
    comb = (ba * oa) >>> 12;
    intens = (longint'(str) * 512) / 125;
    o[0] = longint'($signed(px.orig_luma));
    o[1] = longint'($signed(px.orig_cb));
    o[2] = longint'($signed(px.orig_cr));
    b[0] = longint'($signed(px.blur_luma));
    b[1] = longint'($signed(px.blur_cb));
    b[2] = longint'($signed(px.blur_cr));
    for (int i = 0; i < 3; i++) r[i] = o[i];
    if (str != 0 && comb > 0) begin
      for (int i = 0; i < 3; i++) begin
        // SystemVerilog signed division truncates toward zero, as needed here.
        if (comb >= 4096) d = o[i] - b[i];
        else d = (o[i] * oa - b[i] * 4096) / comb;
        r[i] = o[i] + floor_shift(d * intens, 12);
      end
      // Negative luma darkens the chroma, then luma clamps to zero.
      if (r[0] < 0) begin
        s = r[0] + 1024;
        if (s <= 0) begin
          r[1] = 0;
          r[2] = 0;
        end else begin
          r[1] = floor_shift(r[1] * s, 10);
          r[2] = floor_shift(r[2] * s, 10);
        end
        r[0] = 0;
      end
    end
    res.luma  = r[0][15:0];
    res.cb    = r[1][15:0];
    res.cr    = r[2][15:0];
    res.alpha = px.orig_alpha;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic pixel_in_t make_pixel(int ol, int ocb, int ocr, int oa,
                                           int bl, int bcb, int bcr, int ba);
    pixel_in_t p;
    p.orig_luma = ol[15:0];
    p.orig_cb = ocb[15:0];
    p.orig_cr = ocr[15:0];
    p.orig_alpha = oa[12:0];
    p.blur_luma = bl[15:0];
    p.blur_cb = bcb[15:0];
    p.blur_cr = bcr[15:0];
    p.blur_alpha = ba[12:0];
    return p;
  endfunction

  // Random pixel: mostly nominal video, sometimes full-range noise, with
  // alpha biased toward opaque, transparent and partial values.
  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    int sel;
    p = pixel_in_t'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      p.orig_luma = 16'($urandom_range(0, 4096));
      p.orig_cb   = 16'($urandom_range(0, 4096) - 2048);
      p.orig_cr   = 16'($urandom_range(0, 4096) - 2048);
      p.blur_luma = 16'($urandom_range(0, 4096));
      p.blur_cb   = 16'($urandom_range(0, 4096) - 2048);
      p.blur_cr   = 16'($urandom_range(0, 4096) - 2048);
    end
    for (int k = 0; k < 2; k++) begin
      logic [12:0] al;
      sel = $urandom_range(0, 9);
      if (sel < 3) al = 13'd4096;
      else if (sel < 4) al = 13'd0;
      else if (sel < 9) al = 13'($urandom_range(1, 4096));
      else al = 13'($urandom);
      if (k == 0) p.orig_alpha = al;
      else p.blur_alpha = al;
    end
    return p;
  endfunction

  // Sends one pixel, idling first for a random number of cycles. Valid stays
  // high after the transaction so that back-to-back pixels need no gap.
  task automatic send_pixel(pixel_in_t px);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= 128'(px);
    in_tvalid <= 1'b1;
    sharpened_q.push_back(sharpen_pixel(px, strength_q));
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Waits until every expected pixel has come back, then lets the pipe drain.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sharpened_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_strength(logic [9:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    strength_q = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall before each transaction, some stretches without.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Checker: compares each accepted output transaction with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sharpened_q.size() == 0) begin
        report_mismatch("unexpected", out_tdata[15:0], 16'd0);
      end else begin
        pixel_out_t want, got;
        want = sharpened_q.pop_front();
        got = pixel_out_t'(out_tdata[60:0]);
        if (got.luma !== want.luma) report_mismatch("luma", got.luma, want.luma);
        if (got.cb !== want.cb) report_mismatch("cb", got.cb, want.cb);
        if (got.cr !== want.cr) report_mismatch("cr", got.cr, want.cr);
        if (got.alpha !== want.alpha)
          report_mismatch("alpha", 16'(got.alpha), 16'(want.alpha));
        if (out_tdata[63:61] !== 3'd0) report_mismatch("fill", 16'(out_tdata[63:61]), 0);
      end
    end
  end

  // Main stimulus.
  initial begin
    dir_row_t dir_tab[$];
    dir_row_t row;
    logic [9:0] settings[6];
    pixel_in_t px;
    n_errors  = 0;
    strength_q = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, phase one at reset strength zero: every pixel passes through.
    row.has_exp = 1;
    row.px = make_pixel(32767, -32768, 32767, 4096, -32768, 32767, -32768, 4096);
    row.exp_px = {13'd4096, 16'h7fff, 16'h8000, 16'h7fff};
    dir_tab.push_back(row);
    row.px = make_pixel(-32768, 32767, -32768, 8191, 0, 0, 0, 8191);
    row.exp_px = {13'd8191, 16'h8000, 16'h7fff, 16'h8000};
    dir_tab.push_back(row);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp &&
          sharpen_pixel(dir_tab[i].px, strength_q) !== dir_tab[i].exp_px)
        report_mismatch("table", 0, 0);
      send_pixel(dir_tab[i].px);
    end
    wait_drained();

    // Phase two at strength 1000: transparent, opaque, partial, dark fringe,
    // out-of-range alpha and wide overflow.
    write_strength(10'd1000);
    dir_tab.delete();
    row.has_exp = 1;
    // Transparent pixel: combined alpha is zero, so the original passes.
    row.px = make_pixel(1000, -500, 300, 0, 4000, 100, 100, 4096);
    row.exp_px = {13'd0, 16'd300, 16'hfe0c, 16'd1000};
    dir_tab.push_back(row);
    row.px = make_pixel(1000, -500, 300, 1, 4000, 100, 100, 1);
    row.exp_px = {13'd1, 16'd300, 16'hfe0c, 16'd1000};
    dir_tab.push_back(row);
    row.has_exp = 0;
    dir_tab.push_back('{make_pixel(2048, 100, -100, 4096, 1024, 0, 0, 4096), 0, '0});
    dir_tab.push_back('{make_pixel(200, 1000, -1000, 4096, 4000, 0, 0, 4096), 0, '0});
    dir_tab.push_back('{make_pixel(100, 900, -900, 4096, 1500, 0, 0, 4096), 0, '0});
    dir_tab.push_back('{make_pixel(3000, 500, 500, 2048, 1000, 200, 200, 4096), 0, '0});
    dir_tab.push_back('{make_pixel(3000, 500, 500, 4096, 1000, 200, 200, 64), 0, '0});
    dir_tab.push_back('{make_pixel(32767, 32767, -32768, 4096, -32768, -32768,
                                   32767, 4096), 0, '0});
    dir_tab.push_back('{make_pixel(-32768, -32768, 32767, 1, 32767, 32767,
                                   -32768, 8191), 0, '0});
    dir_tab.push_back('{make_pixel(100, 200, 300, 8191, 50, 60, 70, 8191), 0, '0});
    dir_tab.push_back('{make_pixel(4096, 0, 0, 4095, 4096, 0, 0, 4095), 0, '0});
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp &&
          sharpen_pixel(dir_tab[i].px, strength_q) !== dir_tab[i].exp_px)
        report_mismatch("table", 0, 0);
      send_pixel(dir_tab[i].px);
    end
    wait_drained();

    // Random part across several strengths, the extremes among them.
    settings = '{10'd1, 10'd1000, 10'd1023, 10'd0, 10'd500, 10'h2aa};
    for (int s = 0; s < 6; s++) begin
      write_strength((s == 5) ? 10'($urandom) : settings[s]);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        px = random_pixel();
        send_pixel(px);
      end
      wait_drained();
    end

    if (n_errors == 0 && sharpened_q.size() == 0)
      $display("unsharp_mask_combine_yca: match");
    else
      $display("unsharp_mask_combine_yca: mismatch");
    $finish;
  end

endmodule
